// ===== rtl/ktc_pkg.sv =====
package ktc_pkg;

	localparam int MAX_TOKEN_LEN = 127;
	localparam int MAX_ENTRIES = 4096;
	localparam int ENTRY_CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_IDX_W = 12;
	localparam int LEN_W = 7;
	localparam int LINE_W = 16;
	localparam int KW_COUNT = 17;
	localparam int KW_CODE_W = 5;
	localparam int PREFIX_BYTES = 6;
	localparam int PREFIX_W = 8 * PREFIX_BYTES;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [LEN_W-1:0] COL_MAX = '1;
	localparam logic [LINE_W-1:0] LINE_MAX = '1;

	typedef enum logic [2:0] {
		KIND_KEYWORD   = 3'd0,
		KIND_OPERATOR  = 3'd1,
		KIND_PARAMETER = 3'd2,
		KIND_ERROR     = 3'd3,
		KIND_SUCCESS   = 3'd4
	} token_kind_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		token_kind_t            token_kind;
		logic [KW_CODE_W-1:0]   keyword_code;
		logic [7:0]             operator_char;
		logic [ENTRY_IDX_W-1:0] entry_index;
		logic                   owner_valid;
		logic [LINE_W-1:0]      line_number;
		logic [LEN_W-1:0]       start_column;
		logic [LEN_W-1:0]       token_length;
		logic                   last;
	} result_t;

	// keyword text, first byte in the low bits, zero padded
	localparam logic [PREFIX_W-1:0] KW_PREFIX [KW_COUNT] = '{
		48'h0000_0000_6669,  // if
		48'h0000_6573_6c65,  // else
		48'h0000_6669_6c65,  // elif
		48'h0065_6c69_6877,  // while
		48'h6e72_7574_6572,  // return
		48'h0000_0074_6e69,  // int
		48'h0000_0072_6176,  // var
		48'h0000_0072_6f66,  // for
		48'h0000_676e_6f6c,  // long
		48'h0074_726f_6873,  // short
		48'h0000_7469_6e69,  // init
		48'h0000_636e_7566,  // func
		48'h0000_0070_6d69,  // imp
		48'h0000_0074_756f,  // out
		48'h0000_0000_6e69,  // in
		48'h0000_0072_7261,  // arr
		48'h0073_7361_6c63   // class
	};

	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd2, 3'd4, 3'd4, 3'd5, 3'd6, 3'd3, 3'd3, 3'd3, 3'd4,
		3'd5, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd3, 3'd5
	};

endpackage

// ===== rtl/keyword_token_classifier_unit.sv =====
// Lexer for a byte stream: takes one source byte per cycle and reports keywords,
// operators, parameters (integers and identifiers, tied to the latest entry),
// the first error and the final success status. A byte is classed in the cycle
// it is accepted and its results (up to two, such as a word closed by an
// operator) enter a four-deep result queue and are registered there before they
// appear, leaving at one per cycle while result_ready is high. item_ready is
// high while the queue has at least two free slots, giving one byte per cycle
// as long as results are taken at the rate they arise. After an error no further
// results come until reset; after end of input the block starts afresh on the next text.
module keyword_token_classifier_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  ktc_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output ktc_pkg::result_t  result
);

	function automatic logic is_op(input logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == ">" ||
		       c == "<" || c == "=" || c == "%" || c == "!";
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return is_op(c) || c == " " || c == "," || c == ";" || c == "(" ||
		       c == ")" || c == "[" || c == "]" || c == "{" || c == "}";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// word and position state
	logic [ktc_pkg::PREFIX_W-1:0]    prefix_q, prefix_d;
	logic [ktc_pkg::LEN_W-1:0]       wlen_q, wlen_d;
	logic [ktc_pkg::LEN_W-1:0]       wstart_q, wstart_d;
	logic [ktc_pkg::LEN_W-1:0]       column_q, column_d;
	logic [ktc_pkg::LINE_W-1:0]      line_q, line_d;
	logic                            digits_q, digits_d;
	logic                            ident_q, ident_d;
	logic [ktc_pkg::ENTRY_CNT_W-1:0] entries_q, entries_d;
	logic                            error_q, error_d;

	// result queue
	ktc_pkg::result_t                fifo_q [ktc_pkg::QDEPTH];
	logic [ktc_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [ktc_pkg::QCNT_W-1:0]      count_q;

	logic                            accept, pop;
	logic [1:0]                      push_n;
	ktc_pkg::result_t                res0, res1;

	logic                            kw_hit;
	logic [ktc_pkg::KW_CODE_W-1:0]   kw_code;
	ktc_pkg::result_t                fl, op_res, done_res;
	logic                            fl_err;
	logic [ktc_pkg::ENTRY_CNT_W-1:0] cnt_fl, cnt_op;
	logic [ktc_pkg::LEN_W-1:0]       col_inc;
	logic                            word_byte;

	assign accept       = item_valid && item_ready;
	assign pop          = result_valid && result_ready;
	assign item_ready   = (ktc_pkg::QCNT_W'(ktc_pkg::QDEPTH) - count_q) >= ktc_pkg::QCNT_W'(2);
	assign result_valid = count_q != '0;
	assign result       = fifo_q[rd_ptr_q];

	assign word_byte = !is_delim(item.char_code) && item.char_code != 8'h0a &&
	                   item.char_code != 8'h00;
	assign col_inc   = (column_q == ktc_pkg::COL_MAX) ? column_q : column_q + 1'b1;

	always_comb begin
		kw_hit  = 1'b0;
		kw_code = '0;
		for (int i = ktc_pkg::KW_COUNT - 1; i >= 0; i--) begin
			if (prefix_q == ktc_pkg::KW_PREFIX[i] &&
			    wlen_q == ktc_pkg::LEN_W'(ktc_pkg::KW_LEN[i])) begin
				kw_hit  = 1'b1;
				kw_code = ktc_pkg::KW_CODE_W'(i);
			end
		end
	end

	// classify the pending word
	always_comb begin
		fl              = '0;
		fl.line_number  = line_q;
		fl.start_column = wstart_q;
		fl.token_length = wlen_q;
		fl_err          = 1'b0;
		cnt_fl          = entries_q;
		if (kw_hit) begin
			fl.token_kind   = ktc_pkg::KIND_KEYWORD;
			fl.keyword_code = kw_code;
			fl.owner_valid  = 1'b1;
			if (entries_q < ktc_pkg::ENTRY_CNT_W'(ktc_pkg::MAX_ENTRIES)) begin
				fl.entry_index = ktc_pkg::ENTRY_IDX_W'(entries_q);
				cnt_fl         = entries_q + 1'b1;
			end else begin
				fl.entry_index = ktc_pkg::ENTRY_IDX_W'(ktc_pkg::MAX_ENTRIES - 1);
			end
		end else if (digits_q || ident_q) begin
			fl.token_kind = ktc_pkg::KIND_PARAMETER;
			if (entries_q != '0) begin
				fl.entry_index = ktc_pkg::ENTRY_IDX_W'(entries_q - 1'b1);
				fl.owner_valid = 1'b1;
			end
		end else begin
			fl.token_kind = ktc_pkg::KIND_ERROR;
			fl_err        = 1'b1;
		end
	end

	always_comb begin
		op_res               = '0;
		op_res.token_kind    = ktc_pkg::KIND_OPERATOR;
		op_res.operator_char = item.char_code;
		op_res.owner_valid   = 1'b1;
		op_res.line_number   = line_q;
		op_res.start_column  = column_q;
		op_res.token_length  = ktc_pkg::LEN_W'(1);
		op_res.last          = 1'b1;
		cnt_op               = cnt_fl;
		if (cnt_fl < ktc_pkg::ENTRY_CNT_W'(ktc_pkg::MAX_ENTRIES)) begin
			op_res.entry_index = ktc_pkg::ENTRY_IDX_W'(cnt_fl);
			cnt_op             = cnt_fl + 1'b1;
		end else begin
			op_res.entry_index = ktc_pkg::ENTRY_IDX_W'(ktc_pkg::MAX_ENTRIES - 1);
		end
	end

	always_comb begin
		done_res              = '0;
		done_res.token_kind   = ktc_pkg::KIND_SUCCESS;
		done_res.line_number  = line_q;
		done_res.start_column = column_q;
		done_res.last         = 1'b1;
	end

	always_comb begin
		prefix_d  = prefix_q;
		wlen_d    = wlen_q;
		wstart_d  = wstart_q;
		column_d  = column_q;
		line_d    = line_q;
		digits_d  = digits_q;
		ident_d   = ident_q;
		entries_d = entries_q;
		error_d   = error_q;
		push_n    = 2'd0;
		res0      = fl;
		res1      = op_res;
		if (accept && !error_q) begin
			if (item.end_of_input) begin
				if (wlen_q != '0 && fl_err) begin
					res0.last = 1'b1;
					push_n    = 2'd1;
					error_d   = 1'b1;
				end else begin
					if (wlen_q != '0) begin
						res1   = done_res;
						push_n = 2'd2;
					end else begin
						res0   = done_res;
						push_n = 2'd1;
					end
					entries_d = '0;
					line_d    = ktc_pkg::LINE_W'(1);
					column_d  = '0;
				end
				prefix_d = '0;
				wlen_d   = '0;
				wstart_d = '0;
				digits_d = 1'b1;
				ident_d  = 1'b1;
			end else if (word_byte) begin
				if (wlen_q >= ktc_pkg::LEN_W'(ktc_pkg::MAX_TOKEN_LEN)) begin
					res0              = '0;
					res0.token_kind   = ktc_pkg::KIND_ERROR;
					res0.line_number  = line_q;
					res0.start_column = wstart_q;
					res0.token_length = ktc_pkg::LEN_W'(ktc_pkg::MAX_TOKEN_LEN);
					res0.last         = 1'b1;
					push_n            = 2'd1;
					error_d           = 1'b1;
				end else begin
					if (wlen_q == '0) begin
						wstart_d = column_q;
						ident_d  = is_alpha(item.char_code) || item.char_code == "_";
					end else begin
						ident_d = ident_q && (is_alpha(item.char_code) ||
						          is_digit(item.char_code) || item.char_code == "_");
					end
					digits_d = digits_q && is_digit(item.char_code);
					for (int i = 0; i < ktc_pkg::PREFIX_BYTES; i++) begin
						if (wlen_q == ktc_pkg::LEN_W'(i))
							prefix_d[8*i +: 8] = item.char_code;
					end
					wlen_d   = wlen_q + 1'b1;
					column_d = col_inc;
				end
			end else begin
				if (wlen_q != '0) begin
					prefix_d = '0;
					wlen_d   = '0;
					wstart_d = '0;
					digits_d = 1'b1;
					ident_d  = 1'b1;
				end
				if (wlen_q != '0 && fl_err) begin
					res0.last = 1'b1;
					push_n    = 2'd1;
					error_d   = 1'b1;
				end else begin
					entries_d = cnt_fl;
					if (wlen_q != '0) begin
						if (is_op(item.char_code)) begin
							push_n    = 2'd2;
							entries_d = cnt_op;
						end else begin
							res0.last = 1'b1;
							push_n    = 2'd1;
						end
					end else if (is_op(item.char_code)) begin
						res0      = op_res;
						push_n    = 2'd1;
						entries_d = cnt_op;
					end
					if (item.char_code == 8'h0a) begin
						if (line_q != ktc_pkg::LINE_MAX)
							line_d = line_q + 1'b1;
						column_d = '0;
					end else begin
						column_d = col_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q  <= '0;
			wlen_q    <= '0;
			wstart_q  <= '0;
			column_q  <= '0;
			line_q    <= ktc_pkg::LINE_W'(1);
			digits_q  <= 1'b1;
			ident_q   <= 1'b1;
			entries_q <= '0;
			error_q   <= 1'b0;
		end else begin
			prefix_q  <= prefix_d;
			wlen_q    <= wlen_d;
			wstart_q  <= wstart_d;
			column_q  <= column_d;
			line_q    <= line_d;
			digits_q  <= digits_d;
			ident_q   <= ident_d;
			entries_q <= entries_d;
			error_q   <= error_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ktc_pkg::QPTR_W'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + ktc_pkg::QCNT_W'(push_n) - ktc_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			fifo_q[wr_ptr_q] <= res0;
		if (push_n == 2'd2)
			fifo_q[wr_ptr_q + 1'b1] <= res1;
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ktc_pkg::QCNT_W'(ktc_pkg::QDEPTH))
		else $error("result queue overfilled");

	a_entry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entries_q <= ktc_pkg::ENTRY_CNT_W'(ktc_pkg::MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_eoi_reports: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !error_q && item.end_of_input |=> count_q != '0)
		else $error("end of input gave no result");

	a_silent_latch: assert property (@(posedge clk) disable iff (!arst_n)
		error_q |=> error_q && count_q <= $past(count_q))
		else $error("results pushed after error latched");

endmodule
